[rtl/segment_sphere_visibility_test_assert.svh]
// assertion macros for the segment/sphere visibility block
`ifndef SEGMENT_SPHERE_VISIBILITY_TEST_ASSERT_SVH
`define SEGMENT_SPHERE_VISIBILITY_TEST_ASSERT_SVH

// same-cycle implication, clocked on clk, off while arst_n is low
`define SSVT_ASSERT_IMP(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, clocked on clk, off while arst_n is low
`define SSVT_ASSERT_NXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/ssvt_pkg.sv]
// package: widths, sideband type and register codes for the segment/sphere test
`timescale 1ns / 1ps
`default_nettype none

package ssvt_pkg;

	// coordinate and difference widths
	localparam int COORD_W = 31;
	localparam int D_W = COORD_W + 1;

	// radius register
	localparam int RADIUS_W = 30;
	localparam logic [RADIUS_W-1:0] RADIUS_RESET = RADIUS_W'(6371008);

	// config port
	localparam int DATA_W = 32;
	localparam int ADDR_W = 3;
	localparam int REG_IDX_W = ADDR_W - 2;
	localparam logic [REG_IDX_W-1:0] REG_RADIUS = '0;

	// datapath widths
	localparam int PROD_W = 2 * D_W;
	localparam int HALF_W = PROD_W / 2;
	localparam int B_W = PROD_W + 1;
	localparam int TWO_A_W = PROD_W + 1;
	localparam int SQ_W = 2 * PROD_W;
	localparam int DISC_W = SQ_W + 2;
	localparam int ROOT_W = DISC_W / 2;
	localparam int REM_W = ROOT_W + 2;
	localparam int N_W = ROOT_W + 2;

	typedef logic signed [COORD_W-1:0] coord_t;

	// values that ride alongside the square root
	typedef struct packed {
		logic                      early;
		logic signed [B_W-1:0]     b;
		logic [TWO_A_W-1:0]        two_a;
	} ssvt_side_t;

endpackage

`default_nettype wire

[rtl/ssvt_isqrt.sv]
// pipelined floor square root, one result bit per stage, with sideband
`timescale 1ns / 1ps
`default_nettype none

module ssvt_isqrt import ssvt_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              en,
	input  wire logic              in_valid,
	input  wire logic [DISC_W-1:0] in_rad,
	input  wire ssvt_side_t        in_side,
	output logic                   out_valid,
	output logic [ROOT_W-1:0]      out_root,
	output ssvt_side_t             out_side
);

	// stage registers, index k holds the word after step k
	logic                vld_sn  [ROOT_W];
	logic [DISC_W-1:0]   rad_sn  [ROOT_W];
	logic [REM_W-1:0]    rem_sn  [ROOT_W];
	logic [ROOT_W-1:0]   root_sn [ROOT_W];
	ssvt_side_t          side_sn [ROOT_W];

	// inputs of each step
	logic [DISC_W-1:0]   rad_pv  [ROOT_W];
	logic [REM_W-1:0]    rem_pv  [ROOT_W];
	logic [ROOT_W-1:0]   root_pv [ROOT_W];
	ssvt_side_t          side_pv [ROOT_W];

	// step results
	logic [REM_W-1:0]    rem_sh  [ROOT_W];
	logic [REM_W-1:0]    trial   [ROOT_W];
	logic [REM_W:0]      diff    [ROOT_W];
	logic                take    [ROOT_W];
	logic [DISC_W-1:0]   rad_nx  [ROOT_W];
	logic [REM_W-1:0]    rem_nx  [ROOT_W];
	logic [ROOT_W-1:0]   root_nx [ROOT_W];

	// step inputs: first step from the ports, the rest from the stage before
	always_comb begin
		rad_pv[0]  = in_rad;
		rem_pv[0]  = '0;
		root_pv[0] = '0;
		side_pv[0] = in_side;
		for (int k = 1; k < ROOT_W; k++) begin
			rad_pv[k]  = rad_sn[k-1];
			rem_pv[k]  = rem_sn[k-1];
			root_pv[k] = root_sn[k-1];
			side_pv[k] = side_sn[k-1];
		end
	end

	// one restoring root step per stage: bring down two bits, try root*4+1
	always_comb begin
		for (int k = 0; k < ROOT_W; k++) begin
			rem_sh[k]  = {rem_pv[k][REM_W-3:0], rad_pv[k][DISC_W-1:DISC_W-2]};
			trial[k]   = {root_pv[k], 2'b01};
			diff[k]    = {1'b0, rem_sh[k]} - {1'b0, trial[k]};
			take[k]    = !diff[k][REM_W];
			rem_nx[k]  = take[k] ? diff[k][REM_W-1:0] : rem_sh[k];
			root_nx[k] = {root_pv[k][ROOT_W-2:0], take[k]};
			rad_nx[k]  = {rad_pv[k][DISC_W-3:0], 2'b00};
		end
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < ROOT_W; k++) vld_sn[k] <= 1'b0;
		end else if (en) begin
			vld_sn[0] <= in_valid;
			for (int k = 1; k < ROOT_W; k++) vld_sn[k] <= vld_sn[k-1];
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < ROOT_W; k++) begin
				rad_sn[k]  <= rad_nx[k];
				rem_sn[k]  <= rem_nx[k];
				root_sn[k] <= root_nx[k];
				side_sn[k] <= side_pv[k];
			end
		end
	end

	assign out_valid = vld_sn[ROOT_W-1];
	assign out_root  = root_sn[ROOT_W-1];
	assign out_side  = side_sn[ROOT_W-1];

endmodule

`default_nettype wire

[rtl/segment_sphere_visibility_test.sv]
// top level: segment versus sphere visibility test, pipelined
//
// Input channel: in_valid/in_stall with two points (start_*, end_*), signed
// meters. A word is taken at a rising edge with in_valid high and in_stall low.
// Output channel: out_valid/out_stall with clear_path, one word per input word,
// in input order; clear_path is 1 when the segment stays clear of the sphere.
// The sphere radius sits in an APB register at byte address 0 and must only be
// written while no word is in flight.
// Throughput: one word per clock while the output is not stalled. A word
// passes seven stages of products and sums, the 65-stage square-root
// pipeline and two compare stages on its way to out_valid, after the input
// skid register if it waited there.
// While out_stall holds a valid output word the whole pipeline freezes; the
// input still takes one more word into its skid register, then raises in_stall.
// Reset empties the pipeline and the skid register and loads the default
// radius of 6371008 m.
`timescale 1ns / 1ps
`default_nettype none
`include "segment_sphere_visibility_test_assert.svh"

module segment_sphere_visibility_test import ssvt_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	// config port
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [ADDR_W-1:0] paddr,
	input  wire logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0]      prdata,
	output logic                   pready,
	// input channel
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire coord_t            start_x,
	input  wire coord_t            start_y,
	input  wire coord_t            start_z,
	input  wire coord_t            end_x,
	input  wire coord_t            end_y,
	input  wire coord_t            end_z,
	// output channel
	output logic                   out_valid,
	input  wire logic              out_stall,
	output logic                   clear_path
);

	typedef struct packed {
		coord_t sx;
		coord_t sy;
		coord_t sz;
		coord_t ex;
		coord_t ey;
		coord_t ez;
	} pair_t;

	logic [RADIUS_W-1:0] radius_q;

	logic  en;
	logic  accept;
	logic  src_valid;
	logic  skid_valid_q;
	pair_t skid_q;
	pair_t port_pair;
	pair_t src_pair;

	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5, valid_s6, valid_s7, valid_s8;
	logic out_valid_q;
	logic clear_path_q;

	// stage 1
	logic signed [COORD_W-1:0] s_c  [3];
	logic signed [COORD_W-1:0] e_c  [3];
	logic signed [COORD_W-1:0] s_s1 [3];
	logic signed [D_W-1:0]     d_s1 [3];

	// stage 2
	logic signed [PROD_W-1:0]  dd_c [3];
	logic signed [PROD_W-1:0]  sd_c [3];
	logic signed [PROD_W-1:0]  ss_c [3];
	logic [PROD_W-1:0]         dd_s2 [3];
	logic signed [PROD_W-1:0]  sd_s2 [3];
	logic [PROD_W-1:0]         ss_s2 [3];
	logic [2*RADIUS_W-1:0]     rr_s2;

	// stage 3
	logic signed [PROD_W-1:0]  sd_sum_c;
	logic [PROD_W-1:0]         a_s3;
	logic signed [B_W-1:0]     b_s3;
	logic signed [PROD_W-1:0]  c_s3;

	// stage 4
	logic signed [B_W-1:0]     b_neg_c;
	logic signed [PROD_W-1:0]  c_neg_val_c;
	logic [PROD_W-1:0]         a_s4;
	logic signed [B_W-1:0]     b_s4;
	logic [PROD_W-1:0]         bmag_s4;
	logic [PROD_W-1:0]         cmag_s4;
	logic                      c_neg_s4;
	logic                      a_zero_s4;

	// stage 5
	logic [PROD_W-1:0]         bb_hh_s5, bb_hl_s5, bb_ll_s5;
	logic [PROD_W-1:0]         ac_hh_s5, ac_hl_s5, ac_lh_s5, ac_ll_s5;
	logic [PROD_W-1:0]         a_s5;
	logic signed [B_W-1:0]     b_s5;
	logic                      c_neg_s5;
	logic                      a_zero_s5;

	// stage 6
	logic [PROD_W:0]           ac_mid_c;
	logic [SQ_W-1:0]           bsq_s6;
	logic [SQ_W-1:0]           ac_s6;
	logic [PROD_W-1:0]         a_s6;
	logic signed [B_W-1:0]     b_s6;
	logic                      c_neg_s6;
	logic                      a_zero_s6;

	// stage 7
	logic [DISC_W-1:0]         disc_s7;
	logic [PROD_W-1:0]         a_s7;
	logic signed [B_W-1:0]     b_s7;
	logic                      a_zero_s7;
	ssvt_side_t                side_c;

	// root pipeline outputs
	logic                      sq_valid;
	logic [ROOT_W-1:0]         sq_root;
	ssvt_side_t                sq_side;

	// stage 8
	logic signed [N_W-1:0]     bx_c;
	logic signed [N_W-1:0]     qx_c;
	logic signed [N_W-1:0]     n1_s8;
	logic signed [N_W-1:0]     n2_s8;
	logic [TWO_A_W-1:0]        two_a_s8;
	logic                      early_s8;

	logic                      clear_c;

	// root parameter numerator strictly between 0 and 2A
	function automatic logic in_open_range(input logic signed [N_W-1:0] n,
			input logic [TWO_A_W-1:0] lim);
		return !n[N_W-1] && (n != '0) && (n[N_W-2:0] < {1'b0, lim});
	endfunction

	// config register
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= RADIUS_RESET;
		end else if (psel && penable && pwrite && paddr[ADDR_W-1:2] == REG_RADIUS) begin
			radius_q <= pwdata[RADIUS_W-1:0];
		end
	end

	always_comb begin
		if (paddr[ADDR_W-1:2] == REG_RADIUS) begin
			prdata = DATA_W'(radius_q);
		end else begin
			prdata = '0;
		end
	end

	// input skid register and pipeline enable
	assign en        = !(out_valid_q && out_stall);
	assign in_stall  = skid_valid_q;
	assign accept    = in_valid && !skid_valid_q;
	assign src_valid = skid_valid_q || in_valid;

	assign port_pair = '{sx: start_x, sy: start_y, sz: start_z,
		ex: end_x, ey: end_y, ez: end_z};
	assign src_pair  = skid_valid_q ? skid_q : port_pair;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skid_valid_q <= 1'b0;
		end else if (en) begin
			skid_valid_q <= 1'b0;
		end else if (accept) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!en && accept) begin
			skid_q <= port_pair;
		end
	end

	// valid bits travel with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			valid_s3    <= 1'b0;
			valid_s4    <= 1'b0;
			valid_s5    <= 1'b0;
			valid_s6    <= 1'b0;
			valid_s7    <= 1'b0;
			valid_s8    <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			valid_s1    <= src_valid;
			valid_s2    <= valid_s1;
			valid_s3    <= valid_s2;
			valid_s4    <= valid_s3;
			valid_s5    <= valid_s4;
			valid_s6    <= valid_s5;
			valid_s7    <= valid_s6;
			valid_s8    <= sq_valid;
			out_valid_q <= valid_s8;
		end
	end

	// stage 1: direction d = E - S
	always_comb begin
		s_c[0] = src_pair.sx;
		s_c[1] = src_pair.sy;
		s_c[2] = src_pair.sz;
		e_c[0] = src_pair.ex;
		e_c[1] = src_pair.ey;
		e_c[2] = src_pair.ez;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				s_s1[i] <= s_c[i];
				d_s1[i] <= D_W'(e_c[i]) - D_W'(s_c[i]);
			end
		end
	end

	// stage 2: per-axis products and r squared
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			dd_c[i] = d_s1[i] * d_s1[i];
			sd_c[i] = s_s1[i] * d_s1[i];
			ss_c[i] = s_s1[i] * s_s1[i];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				dd_s2[i] <= dd_c[i];
				sd_s2[i] <= sd_c[i];
				ss_s2[i] <= ss_c[i];
			end
			rr_s2 <= radius_q * radius_q;
		end
	end

	// stage 3: A = d.d, B = 2 s.d, C = s.s - r^2
	assign sd_sum_c = sd_s2[0] + sd_s2[1] + sd_s2[2];

	always_ff @(posedge clk) begin
		if (en) begin
			a_s3 <= dd_s2[0] + dd_s2[1] + dd_s2[2];
			b_s3 <= {sd_sum_c, 1'b0};
			c_s3 <= ss_s2[0] + ss_s2[1] + ss_s2[2] - PROD_W'(rr_s2);
		end
	end

	// stage 4: magnitudes of B and C
	assign b_neg_c     = -b_s3;
	assign c_neg_val_c = -c_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			a_s4      <= a_s3;
			b_s4      <= b_s3;
			bmag_s4   <= b_s3[B_W-1] ? PROD_W'(b_neg_c) : PROD_W'(b_s3);
			cmag_s4   <= c_s3[PROD_W-1] ? c_neg_val_c : c_s3;
			c_neg_s4  <= c_s3[PROD_W-1];
			a_zero_s4 <= (a_s3 == '0);
		end
	end

	// stage 5: half-word partial products of B*B and A*|C|
	always_ff @(posedge clk) begin
		if (en) begin
			bb_hh_s5  <= bmag_s4[PROD_W-1:HALF_W] * bmag_s4[PROD_W-1:HALF_W];
			bb_hl_s5  <= bmag_s4[PROD_W-1:HALF_W] * bmag_s4[HALF_W-1:0];
			bb_ll_s5  <= bmag_s4[HALF_W-1:0] * bmag_s4[HALF_W-1:0];
			ac_hh_s5  <= a_s4[PROD_W-1:HALF_W] * cmag_s4[PROD_W-1:HALF_W];
			ac_hl_s5  <= a_s4[PROD_W-1:HALF_W] * cmag_s4[HALF_W-1:0];
			ac_lh_s5  <= a_s4[HALF_W-1:0] * cmag_s4[PROD_W-1:HALF_W];
			ac_ll_s5  <= a_s4[HALF_W-1:0] * cmag_s4[HALF_W-1:0];
			a_s5      <= a_s4;
			b_s5      <= b_s4;
			c_neg_s5  <= c_neg_s4;
			a_zero_s5 <= a_zero_s4;
		end
	end

	// stage 6: assemble the two wide products
	assign ac_mid_c = {1'b0, ac_hl_s5} + {1'b0, ac_lh_s5};

	always_ff @(posedge clk) begin
		if (en) begin
			bsq_s6    <= {bb_hh_s5, bb_ll_s5} + (SQ_W'({bb_hl_s5, 1'b0}) << HALF_W);
			ac_s6     <= {ac_hh_s5, ac_ll_s5} + (SQ_W'(ac_mid_c) << HALF_W);
			a_s6      <= a_s5;
			b_s6      <= b_s5;
			c_neg_s6  <= c_neg_s5;
			a_zero_s6 <= a_zero_s5;
		end
	end

	// stage 7: discriminant B^2 - 4AC
	always_ff @(posedge clk) begin
		if (en) begin
			if (c_neg_s6) begin
				disc_s7 <= DISC_W'(bsq_s6) + {ac_s6, 2'b00};
			end else begin
				disc_s7 <= DISC_W'(bsq_s6) - {ac_s6, 2'b00};
			end
			a_s7      <= a_s6;
			b_s7      <= b_s6;
			a_zero_s7 <= a_zero_s6;
		end
	end

	// degenerate segment or negative discriminant decides the answer early
	always_comb begin
		side_c.early = a_zero_s7 || disc_s7[DISC_W-1];
		side_c.b     = b_s7;
		side_c.two_a = {a_s7, 1'b0};
	end

	ssvt_isqrt u_isqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (valid_s7),
		.in_rad    (disc_s7),
		.in_side   (side_c),
		.out_valid (sq_valid),
		.out_root  (sq_root),
		.out_side  (sq_side)
	);

	// stage 8: root numerators -B - q and -B + q
	assign bx_c = N_W'(sq_side.b);
	assign qx_c = $signed({2'b00, sq_root});

	always_ff @(posedge clk) begin
		if (en) begin
			n1_s8    <= -bx_c - qx_c;
			n2_s8    <= -bx_c + qx_c;
			two_a_s8 <= sq_side.two_a;
			early_s8 <= sq_side.early;
		end
	end

	// output register: blocked when either root lies strictly inside the segment
	assign clear_c = early_s8 ||
		!(in_open_range(n1_s8, two_a_s8) || in_open_range(n2_s8, two_a_s8));

	always_ff @(posedge clk) begin
		if (en) begin
			clear_path_q <= clear_c;
		end
	end

	assign out_valid  = out_valid_q;
	assign clear_path = clear_path_q;

	// checks
	`SSVT_ASSERT_NXT(a_skid_drains, skid_valid_q && en, !skid_valid_q, "skid word not drained")
	`SSVT_ASSERT_IMP(a_skid_blocked, skid_valid_q, $past(out_valid_q && out_stall), "skid filled while output free")
	`SSVT_ASSERT_NXT(a_disc_sign, en && valid_s6 && c_neg_s6, !disc_s7[DISC_W-1], "negative discriminant with C below zero")

endmodule

`default_nettype wire
